// ===== hdl/bresenham_line_stepper_defines.svh =====
// assertion macros used by the line stepper back end
// expects clk and rst in the scope of each use
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define BLS_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("line stepper check failed");

// condition in this cycle implies consequence in the next cycle
`define BLS_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("line stepper check failed");

`endif

// ===== hdl/bls_pkg.sv =====
// types and constants of the bresenham line stepper
// no dependencies
package bls_pkg;

  localparam int COORD_W = 9;
  localparam int ERR_W   = COORD_W + 3;
  localparam int CNT_W   = COORD_W + 1;
  localparam int COLOR_W = 16;

  localparam int CMD_DEPTH_DEFAULT = 2;
  localparam int OUT_DEPTH_DEFAULT = 2;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } out_item_t;

  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COLOR_W-1:0] color;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] inc_straight;
    logic signed [ERR_W-1:0] inc_diagonal;
    logic               x_major;
    logic               x_down;
    logic               y_down;
    logic [CNT_W-1:0]   count;
  } cmd_t;

endpackage

// ===== hdl/bls_fifo.sv =====
// small show-ahead queue of any packed type
// no dependencies
module bls_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

// ===== hdl/bls_front.sv =====
// front end: classifies requests and computes line setup
// depends on bls_pkg
module bls_front (
  input  bls_pkg::in_item_t item,
  output bls_pkg::cmd_t     cmd
);
  import bls_pkg::*;

  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [COORD_W-1:0] major;
  logic [COORD_W-1:0] minor;
  logic               x_major;
  logic signed [ERR_W-1:0] minor2;
  logic signed [ERR_W-1:0] major1;
  logic signed [ERR_W-1:0] major2;

  always_comb begin
    dx      = (item.x_end > item.x_start) ? item.x_end - item.x_start
                                          : item.x_start - item.x_end;
    dy      = (item.y_end > item.y_start) ? item.y_end - item.y_start
                                          : item.y_start - item.y_end;
    x_major = (dx >= dy);
    major   = x_major ? dx : dy;
    minor   = x_major ? dy : dx;
    minor2  = $signed({2'b00, minor, 1'b0});
    major1  = $signed({3'b000, major});
    major2  = $signed({2'b00, major, 1'b0});

    cmd.is_load      = (item.req_type == REQ_LOAD);
    cmd.x0           = item.x_start;
    cmd.y0           = item.y_start;
    cmd.color        = item.line_color;
    cmd.err          = minor2 - major1;
    cmd.inc_straight = minor2;
    cmd.inc_diagonal = minor2 - major2;
    cmd.x_major      = x_major;
    cmd.x_down       = (item.x_start > item.x_end);
    cmd.y_down       = (item.y_start > item.y_end);
    cmd.count        = {1'b0, major} + CNT_W'(1);
  end
endmodule

// ===== hdl/bls_back.sv =====
// back end: holds the line state and steps one pixel per pixel command while a line is active
// depends on bls_pkg and bresenham_line_stepper_defines.svh
`include "bresenham_line_stepper_defines.svh"

module bls_back (
  input  logic               clk,
  input  logic               rst,
  input  bls_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic               out_full,
  output logic               out_push,
  output bls_pkg::out_item_t out_item
);
  import bls_pkg::*;

  logic                    line_active;
  logic [COORD_W-1:0]      cur_x;
  logic [COORD_W-1:0]      cur_y;
  logic signed [ERR_W-1:0] error_term;
  logic signed [ERR_W-1:0] inc_straight;
  logic signed [ERR_W-1:0] inc_diagonal;
  logic                    x_major;
  logic                    x_down;
  logic                    y_down;
  logic [CNT_W-1:0]        pixels_left;
  logic [COLOR_W-1:0]      held_color;
  logic                    last;
  logic                    straight;
  logic [COORD_W-1:0]      x_step;
  logic [COORD_W-1:0]      y_step;

  assign cmd_pop  = !cmd_empty && (cmd.is_load || !line_active || !out_full);
  assign out_push = cmd_pop && !cmd.is_load && line_active;
  assign last     = (pixels_left <= CNT_W'(1));
  assign straight = error_term[ERR_W-1];
  assign x_step   = x_down ? cur_x - 1'b1 : cur_x + 1'b1;
  assign y_step   = y_down ? cur_y - 1'b1 : cur_y + 1'b1;

  always_comb begin
    out_item.pixel_x     = cur_x;
    out_item.pixel_y     = cur_y;
    out_item.pixel_color = held_color;
    out_item.last_pixel  = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (cmd_pop && cmd.is_load) begin
      line_active <= 1'b1;
    end else if (out_push && last) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.is_load) begin
      cur_x        <= cmd.x0;
      cur_y        <= cmd.y0;
      error_term   <= cmd.err;
      inc_straight <= cmd.inc_straight;
      inc_diagonal <= cmd.inc_diagonal;
      x_major      <= cmd.x_major;
      x_down       <= cmd.x_down;
      y_down       <= cmd.y_down;
      pixels_left  <= cmd.count;
      held_color   <= cmd.color;
    end else if (out_push) begin
      if (last) begin
        pixels_left <= '0;
      end else begin
        pixels_left <= pixels_left - 1'b1;
        if (straight) begin
          error_term <= error_term + inc_straight;
          if (x_major) begin
            cur_x <= x_step;
          end else begin
            cur_y <= y_step;
          end
        end else begin
          error_term <= error_term + inc_diagonal;
          cur_x      <= x_step;
          cur_y      <= y_step;
        end
      end
    end
  end

  `BLS_ASSERT_NOW(a_active_has_pixels, line_active, pixels_left != '0)
  `BLS_ASSERT_NOW(a_emit_needs_line, out_push, line_active && !out_full)
  `BLS_ASSERT_NEXT(a_last_ends_line, out_push && last, !line_active)
endmodule

// ===== hdl/bresenham_line_stepper.sv =====
// top level of the bresenham line stepper: front end, command queue,
// back end and result queue; depends on bls_pkg and the bls_* modules
//
// channel   signals                     direction
// request   push, full, item            in: load a line or ask for a pixel
// result    pop, empty, result          out: one pixel per pixel request on a live line
//
// one request enters per cycle while full is low; a taken request is registered
// in the command queue, and the back end then moves its pixel into the result
// queue, stepping one pixel per cycle while the result queue has room
// reset clears both queues and drops any line in progress
// a full result queue stalls the back end on pixel requests for an active line;
// loads still drain, and full rises once the command queue fills
module bresenham_line_stepper #(
  parameter int CMD_DEPTH = bls_pkg::CMD_DEPTH_DEFAULT,
  parameter int OUT_DEPTH = bls_pkg::OUT_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  bls_pkg::in_item_t  item,
  input  logic               pop,
  output logic               empty,
  output bls_pkg::out_item_t result
);
  import bls_pkg::*;

  cmd_t      front_cmd;
  cmd_t      back_cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      out_full;
  logic      out_push;
  out_item_t out_item;

  bls_front u_front (
    .item (item),
    .cmd  (front_cmd)
  );

  bls_fifo #(
    .T     (cmd_t),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  bls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item)
  );

  bls_fifo #(
    .T     (out_item_t),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_item),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );
endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for bresenham_line_stepper: random line loads and pixel
// requests, a bit-accurate rasterizer prediction and an in-order pixel compare
// depends on bls_pkg and the bresenham_line_stepper rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bls_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int ITEM_TARGET = 800;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;

  typedef enum int {POP_STEADY, POP_HALF, POP_MOSTLY, POP_RARE} pop_mode_e;

  class pixel_tracker;
    logic                    active;
    logic [COORD_W-1:0]      px;
    logic [COORD_W-1:0]      py;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] step_straight;
    logic signed [ERR_W-1:0] step_diag;
    logic                    x_major;
    logic                    x_down;
    logic                    y_down;
    logic [CNT_W-1:0]        remaining;
    logic [COLOR_W-1:0]      color;
    out_item_t               expected_pixels[$];
    int                      errors;
    int                      effective;

    function new();
      active    = 1'b0;
      px        = '0;
      py        = '0;
      err       = '0;
      step_straight = '0;
      step_diag = '0;
      x_major   = 1'b0;
      x_down    = 1'b0;
      y_down    = 1'b0;
      remaining = '0;
      color     = '0;
      errors    = 0;
      effective = 0;
    endfunction

    function void note_request(in_item_t it);
      int dx;
      int dy;
      int major;
      int minor;
      out_item_t pix;
      if (it.req_type == REQ_LOAD) begin
        dx = int'(it.x_end) - int'(it.x_start);
        dy = int'(it.y_end) - int'(it.y_start);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        x_major = (dx >= dy);
        major = x_major ? dx : dy;
        minor = x_major ? dy : dx;
        remaining = CNT_W'(major + 1);
        err = ERR_W'(2 * minor - major);
        step_straight = ERR_W'(2 * minor);
        step_diag = ERR_W'(2 * (minor - major));
        x_down = (it.x_start > it.x_end);
        y_down = (it.y_start > it.y_end);
        px = it.x_start;
        py = it.y_start;
        color = it.line_color;
        active = 1'b1;
        effective++;
      end else if (active) begin
        effective++;
        pix.pixel_x = px;
        pix.pixel_y = py;
        pix.pixel_color = color;
        pix.last_pixel = (remaining <= 1);
        expected_pixels.push_back(pix);
        if (pix.last_pixel) begin
          remaining = '0;
          active = 1'b0;
        end else begin
          if (err < 0) begin
            err = err + step_straight;
            if (x_major) px = x_down ? px - 1'b1 : px + 1'b1;
            else py = y_down ? py - 1'b1 : py + 1'b1;
          end else begin
            err = err + step_diag;
            px = x_down ? px - 1'b1 : px + 1'b1;
            py = y_down ? py - 1'b1 : py + 1'b1;
          end
          remaining = remaining - 1'b1;
        end
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      if (expected_pixels.size() == 0) begin
        $error("pixel with none expected: x %0d y %0d", got.pixel_x, got.pixel_y);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x expected %0d actual %0d", want.pixel_x, got.pixel_x);
        errors++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y expected %0d actual %0d", want.pixel_y, got.pixel_y);
        errors++;
      end
      if (got.pixel_color !== want.pixel_color) begin
        $error("pixel_color expected %h actual %h", want.pixel_color, got.pixel_color);
        errors++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel expected %b actual %b", want.last_pixel, got.last_pixel);
        errors++;
      end
    endfunction
  endclass

  logic      clk  = 1'b0;
  logic      rst  = 1'b1;
  logic      push = 1'b0;
  logic      pop  = 1'b0;
  in_item_t  item = '0;
  logic      full;
  logic      empty;
  out_item_t result;

  pixel_tracker tracker = new();
  bit hold_req   = 1'b0;
  int burst_left = 0;
  int quiet      = 0;

  always #2 clk = ~clk;

  bresenham_line_stepper i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  always @(posedge clk) begin
    if (!rst && push && !full) tracker.note_request(item);
    if (!rst && pop && !empty) tracker.check_pixel(result);
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[bresenham_line_stepper] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: random stall pattern that changes over time, long hold on request
  initial begin
    pop_mode_e mode;
    int        phase;
    phase = 0;
    mode = POP_STEADY;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (phase == 0) begin
          mode = pop_mode_e'($urandom_range(0, 3));
          phase = $urandom_range(16, 96);
        end
        phase--;
        case (mode)
          POP_STEADY: pop <= 1'b1;
          POP_HALF:   pop <= 1'($urandom_range(0, 1));
          POP_MOSTLY: pop <= ($urandom_range(0, 9) != 0);
          POP_RARE:   pop <= ($urandom_range(0, 4) == 0);
          default:    pop <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic in_item_t pixel_request();
    logic [63:0] bits;
    in_item_t    it;
    bits = {$urandom(), $urandom()};
    it = bits[$bits(in_item_t)-1:0];
    it.req_type = REQ_PIXEL;
    return it;
  endfunction

  function automatic in_item_t load_item(int x0, int y0, int x1, int y1, int c);
    in_item_t it;
    it.req_type   = REQ_LOAD;
    it.x_start    = COORD_W'(x0);
    it.y_start    = COORD_W'(y0);
    it.x_end      = COORD_W'(x1);
    it.y_end      = COORD_W'(y1);
    it.line_color = COLOR_W'(c);
    return it;
  endfunction

  function automatic int line_pixels(in_item_t it);
    int dx;
    int dy;
    dx = int'(it.x_end) - int'(it.x_start);
    dy = int'(it.y_end) - int'(it.y_start);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return ((dx >= dy) ? dx : dy) + 1;
  endfunction

  function automatic int near_coord(int c, int reach);
    return $urandom_range((c - reach < 0) ? 0 : c - reach,
                          (c + reach > COORD_MAX) ? COORD_MAX : c + reach);
  endfunction

  task automatic offer_item(input in_item_t it);
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full !== 1'b0);
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    offer_item(it);
  endtask

  task automatic send_line(input in_item_t ld, input int n_req, input bit steady);
    if (steady) offer_item(ld);
    else send_item(ld);
    repeat (n_req) begin
      if (steady) offer_item(pixel_request());
      else send_item(pixel_request());
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (tracker.expected_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin
    in_item_t ld;
    int       reach;
    int       x0;
    int       y0;
    int       n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // request with no line, zero length, equal deltas, replace mid-line, far corner
    send_item(pixel_request());
    send_line(load_item(5, 5, 5, 5, 16'hffff), 2, 1'b0);
    send_line(load_item(0, 0, 2, 2, 16'h0000), 2, 1'b0);
    send_line(load_item(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, 16'ha5a5),
              3, 1'b0);
    send_line(load_item(3, 0, 0, 1, 16'h1234), 4, 1'b0);
    send_line(load_item(0, COORD_MAX, 1, COORD_MAX - 4, 16'h8001), 5, 1'b0);
    wait_drained();

    // receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    send_line(load_item(0, 0, 40, 13, 16'h5a5a), 41, 1'b1);
    wait_drained();

    while (tracker.effective < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 8) begin
        ld = pixel_request();
        if ($urandom_range(0, 1) == 0) ld.req_type = REQ_LOAD;
        send_item(ld);
      end else begin
        reach = ($urandom_range(0, 29) == 0) ? COORD_MAX : $urandom_range(0, 12);
        x0 = $urandom_range(0, COORD_MAX);
        y0 = $urandom_range(0, COORD_MAX);
        ld = load_item(x0, y0, near_coord(x0, reach), near_coord(y0, reach),
                       $urandom_range(0, 16'hffff));
        n = line_pixels(ld);
        case ($urandom_range(0, 6))
          0: n = n + $urandom_range(1, 3);
          1: n = $urandom_range(0, n - 1);
          default: ;
        endcase
        send_line(ld, n, 1'b0);
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);

    if (tracker.expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", tracker.expected_pixels.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("[bresenham_line_stepper] OK");
    end else begin
      $display("[bresenham_line_stepper] ERROR");
    end
    $finish;
  end

endmodule
